@@ rtl/cst_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the counting semaphore table.
// Used by cst_ctrl, cst_dp and counting_semaphore_table_core.
package cst_pkg;

   localparam int FIELD_W = 5;
   localparam int COUNT_W = 17;
   localparam int VALUE_W = 16;
   localparam int COUNT_MAX = 65535;

   typedef enum logic [2:0] {
      CMD_CREATE    = 3'd0,
      CMD_WAIT_TAIL = 3'd1,
      CMD_WAIT_HEAD = 3'd2,
      CMD_SIGNAL    = 3'd3,
      CMD_SIGNAL_N  = 3'd4,
      CMD_DELETE    = 3'd5,
      CMD_RESET     = 3'd6,
      CMD_COUNT     = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD     = 2'd1,
      ST_NO_SLOT = 2'd2
   } status_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic look;
      logic scan;
      logic deliver;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_create;
      logic scan_end;
      logic more;
   } dp_sts_type;

endpackage

@@ rtl/cst_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing state machine for the counting semaphore table.
// Depends on cst_pkg; drives cst_dp through command and status structs.
module cst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  cst_pkg::dp_sts_type sts,
   output cst_pkg::dp_cmd_type cmd
);
   import cst_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_SCAN,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = sts.is_create ? S_SCAN : S_OUT;
         end
         S_SCAN: begin
            if (sts.scan_end) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready && !sts.more) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = (state_ff == S_OUT);
   assign cmd.accept  = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.look    = (state_ff == S_LOOK);
   assign cmd.scan    = (state_ff == S_SCAN);
   assign cmd.deliver = (state_ff == S_OUT) && rsp_tready;

endmodule

@@ rtl/cst_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the counting semaphore table: count, queue head/tail and link
// memories, slot-used bits, allocation cursor and the result register. Uses cst_pkg.
module cst_dp #(
   parameter int NUM_SEMS  = 32,
   parameter int NUM_TASKS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cst_pkg::dp_cmd_type          cmd,
   output cst_pkg::dp_sts_type          sts,
   input  cst_pkg::cmd_type             req_command,
   input  logic [cst_pkg::FIELD_W-1:0]  req_sem_index,
   input  logic [cst_pkg::FIELD_W-1:0]  req_task_id,
   input  logic [cst_pkg::VALUE_W-1:0]  req_value,
   output cst_pkg::status_type          rsp_status,
   output logic [cst_pkg::FIELD_W-1:0]  rsp_new_sem,
   output logic signed [cst_pkg::COUNT_W-1:0] rsp_count_now,
   output logic                         rsp_blocked,
   output logic                         rsp_woken_valid,
   output logic [cst_pkg::FIELD_W-1:0]  rsp_woken_task,
   output logic                         rsp_last
);
   import cst_pkg::*;

   localparam int SW   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int TW   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int QCAP = (NUM_TASKS < 32) ? NUM_TASKS : 32;

   // Memories.
   logic signed [COUNT_W-1:0] count_mem [NUM_SEMS];
   logic [TW-1:0] head_mem [NUM_SEMS];
   logic [TW-1:0] tail_mem [NUM_SEMS];
   logic [TW-1:0] link_mem [NUM_TASKS];

   // Latched request.
   cmd_type              cmd_ff;
   logic [FIELD_W-1:0]   sidx_ff;
   logic [FIELD_W-1:0]   task_ff;
   logic [VALUE_W-1:0]   val_ff;

   // Registered memory reads.
   logic signed [COUNT_W-1:0] cnt_rd_ff;
   logic [TW-1:0] head_rd_ff, tail_rd_ff, link_rd_ff;

   logic [NUM_SEMS-1:0] used_ff, used_in;
   logic [SW-1:0] cursor_ff, cursor_in, scan_cnt_ff, scan_cnt_in;

   // Result register.
   status_type              st_ff, st_in;
   logic [FIELD_W-1:0]      ns_ff, ns_in;
   logic signed [COUNT_W-1:0] cnt_out_ff, cnt_out_in;
   logic                    blk_ff, blk_in, wv_ff, wv_in, last_ff, last_in;
   logic [FIELD_W-1:0]      wt_ff, wt_in;
   logic [5:0]              pops_ff, pops_in;

   // Memory write and read controls.
   logic                      cnt_we, head_we, tail_we, link_we, link_re;
   logic [SW-1:0]             cnt_wa, req_sa, sa;
   logic signed [COUNT_W-1:0] cnt_wd;
   logic [TW-1:0]             head_wd, link_wa, link_wd, link_ra, task_ix;

   assign req_sa  = SW'(req_sem_index);
   assign sa      = SW'(sidx_ff);
   assign task_ix = TW'(task_ff);

   always_comb begin
      logic sem_ok, task_ok, err, hit, last_probe;
      logic signed [COUNT_W-1:0] c, negc, n17, wc, fin;
      logic signed [COUNT_W:0]   sum;
      logic [5:0] pops;

      c       = cnt_rd_ff;
      negc    = -c;
      sem_ok  = (32'(sidx_ff) < NUM_SEMS) && used_ff[sa];
      task_ok = 32'(task_ff) < NUM_TASKS;
      n17     = (cmd_ff == CMD_SIGNAL) ? COUNT_W'(1) : COUNT_W'(val_ff);
      sum     = {c[COUNT_W-1], c} + {1'b0, n17};
      wc      = c - COUNT_W'(1);
      err     = !sem_ok || ((cmd_ff == CMD_SIGNAL_N) && (val_ff == '0)) ||
                (((cmd_ff == CMD_WAIT_TAIL) || (cmd_ff == CMD_WAIT_HEAD)) &&
                 (!task_ok || (c <= -COUNT_W'(QCAP))));
      hit        = !used_ff[cursor_ff];
      last_probe = (scan_cnt_ff == SW'(NUM_SEMS - 1));
      fin     = c;
      pops    = '0;

      st_in = st_ff;  ns_in = ns_ff;  cnt_out_in = cnt_out_ff;
      blk_in = blk_ff; wv_in = wv_ff; wt_in = wt_ff; last_in = last_ff;
      pops_in = pops_ff;
      used_in = used_ff;
      cursor_in = cursor_ff;
      scan_cnt_in = scan_cnt_ff;

      cnt_we = 1'b0; cnt_wa = sa; cnt_wd = c;
      head_we = 1'b0; head_wd = task_ix;
      tail_we = 1'b0;
      link_we = 1'b0; link_wa = tail_rd_ff; link_wd = task_ix;
      link_re = 1'b0; link_ra = head_rd_ff;

      if (cmd.look) begin
         st_in = ST_OK; ns_in = '0; blk_in = 1'b0; wv_in = 1'b0; wt_in = '0;
         last_in = 1'b1; pops_in = '0; cnt_out_in = c; scan_cnt_in = '0;
         if (cmd_ff == CMD_CREATE) begin
            // Result is formed by the scan.
         end else if (err) begin
            st_in = ST_BAD;
            cnt_out_in = '0;
         end else begin
            case (cmd_ff) inside
               CMD_WAIT_TAIL, CMD_WAIT_HEAD: begin
                  cnt_we = 1'b1; cnt_wd = wc; cnt_out_in = wc;
                  if (wc < 0) begin
                     blk_in = 1'b1;
                     if (wc == -COUNT_W'(1)) begin
                        head_we = 1'b1; tail_we = 1'b1;
                     end else if (cmd_ff == CMD_WAIT_TAIL) begin
                        link_we = 1'b1; tail_we = 1'b1;
                     end else begin
                        link_we = 1'b1; link_wa = task_ix; link_wd = head_rd_ff;
                        head_we = 1'b1;
                     end
                  end
               end
               CMD_SIGNAL, CMD_SIGNAL_N, CMD_DELETE, CMD_RESET: begin
                  if (cmd_ff == CMD_SIGNAL || cmd_ff == CMD_SIGNAL_N) begin
                     fin = (sum > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                         : sum[COUNT_W-1:0];
                     if (c < 0) pops = (negc < n17) ? 6'(negc) : 6'(n17);
                  end else begin
                     fin = (cmd_ff == CMD_DELETE) ? '0 : COUNT_W'(val_ff);
                     if (c < 0) pops = 6'(negc);
                     if (cmd_ff == CMD_DELETE) used_in[sa] = 1'b0;
                  end
                  cnt_we = 1'b1; cnt_wd = fin; cnt_out_in = fin;
                  pops_in = pops;
                  if (pops != '0) begin
                     // First released task is the queue head; fetch its link.
                     wv_in = 1'b1; wt_in = FIELD_W'(head_rd_ff);
                     last_in = (pops == 6'd1);
                     link_re = 1'b1; link_ra = head_rd_ff;
                  end
               end
               default: ;
            endcase
         end
      end

      if (cmd.scan) begin
         cursor_in = (cursor_ff == '0) ? SW'(NUM_SEMS - 1) : cursor_ff - SW'(1);
         scan_cnt_in = scan_cnt_ff + SW'(1);
         if (hit) begin
            used_in[cursor_ff] = 1'b1;
            cnt_we = 1'b1; cnt_wa = cursor_ff; cnt_wd = COUNT_W'(val_ff);
            ns_in = FIELD_W'(cursor_ff); cnt_out_in = COUNT_W'(val_ff);
         end else if (last_probe) begin
            st_in = ST_NO_SLOT; cnt_out_in = '0;
         end
      end

      if (cmd.deliver && wv_ff) begin
         // The link of the popped task becomes the new queue head.
         head_we = 1'b1; head_wd = link_rd_ff;
         if (pops_ff > 6'd1) begin
            pops_in = pops_ff - 6'd1;
            wt_in = FIELD_W'(link_rd_ff);
            last_in = (pops_ff == 6'd2);
            link_re = 1'b1; link_ra = link_rd_ff;
         end
      end

      sts.is_create = (cmd_ff == CMD_CREATE);
      sts.scan_end  = hit || last_probe;
      sts.more      = wv_ff && (pops_ff > 6'd1);
   end

   always_ff @(posedge clock) begin
      if (cnt_we)  count_mem[cnt_wa] <= cnt_wd;
      if (head_we) head_mem[sa] <= head_wd;
      if (tail_we) tail_mem[sa] <= task_ix;
      if (link_we) link_mem[link_wa] <= link_wd;
      if (cmd.accept) begin
         cnt_rd_ff  <= count_mem[req_sa];
         head_rd_ff <= head_mem[req_sa];
         tail_rd_ff <= tail_mem[req_sa];
      end
      if (link_re) link_rd_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff  <= req_command;
         sidx_ff <= req_sem_index;
         task_ff <= req_task_id;
         val_ff  <= req_value;
      end
      st_ff <= st_in; ns_ff <= ns_in; cnt_out_ff <= cnt_out_in;
      blk_ff <= blk_in; wv_ff <= wv_in; wt_ff <= wt_in; last_ff <= last_in;
      pops_ff <= pops_in;
      scan_cnt_ff <= scan_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         cursor_ff <= SW'(NUM_SEMS - 1);
      end else begin
         used_ff   <= used_in;
         cursor_ff <= cursor_in;
      end
   end

   assign rsp_status      = st_ff;
   assign rsp_new_sem     = ns_ff;
   assign rsp_count_now   = cnt_out_ff;
   assign rsp_blocked     = blk_ff;
   assign rsp_woken_valid = wv_ff;
   assign rsp_woken_task  = wt_ff;
   assign rsp_last        = last_ff;

endmodule

@@ rtl/counting_semaphore_table_core.sv @@
`timescale 1ns / 1ps
// Counting semaphore table: top level joining cst_ctrl and cst_dp (uses cst_pkg).
// Sequence: the request transfer reads the entry, the look state acts on it, then
// the output state offers the result; create runs the allocation scan in between,
// probing at most NUM_SEMS slots. Throughput: one command at a time; released
// tasks stream one per cycle while rsp_tready is high, paced by the link memory.
// Reset: synchronous; all slots free, allocation cursor at the highest slot.
module counting_semaphore_table_core #(
   parameter int NUM_SEMS  = 32,
   parameter int NUM_TASKS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[2:0], sem_index[7:3], task_id[12:8], value[28:13], zero[31:29]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], new_sem[6:2], count_now[23:7], blocked[24],
   // woken_valid[25], woken_task[30:26], zero[31]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);
   import cst_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   status_type                status;
   logic [FIELD_W-1:0]        new_sem, woken_task;
   logic signed [COUNT_W-1:0] count_now;
   logic                      blocked, woken_valid;

   cst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (dp_sts),
      .cmd        (dp_cmd)
   );

   cst_dp #(
      .NUM_SEMS  (NUM_SEMS),
      .NUM_TASKS (NUM_TASKS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .sts             (dp_sts),
      .req_command     (cmd_type'(req_tdata[2:0])),
      .req_sem_index   (req_tdata[7:3]),
      .req_task_id     (req_tdata[12:8]),
      .req_value       (req_tdata[28:13]),
      .rsp_status      (status),
      .rsp_new_sem     (new_sem),
      .rsp_count_now   (count_now),
      .rsp_blocked     (blocked),
      .rsp_woken_valid (woken_valid),
      .rsp_woken_task  (woken_task),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, woken_task, woken_valid, blocked, count_now,
                       new_sem, status};

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and result sides active together");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready stayed high after a request transfer");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("result run ended without last");

   a_woken_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[25]) |-> (rsp_tdata[1:0] == ST_OK))
      else $error("released task carried an error status");

endmodule
